[rtl/core/wpcn_pkg.sv]
// package with operation codes and shared types of the pair-count normalizer
package wpcn_pkg;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_LOAD   = 3'd1,
        OP_PAIR   = 3'd2,
        OP_RANDOM = 3'd3,
        OP_CLOSE  = 3'd4
    } op_t;

    localparam int TOTAL_W  = 36;
    localparam int SQUARE_W = 60;
    localparam int PAIR_W   = 64;
    localparam int RAND_W   = 36;
    localparam int COUNT_W  = 24;
    localparam int Q_W      = 31;
    localparam int FRAC_SH  = 29;
    localparam int NUM_W    = 128;
    localparam logic [Q_W-1:0] Q31_MAX = {Q_W{1'b1}};

endpackage

[rtl/core/wpcn_ram.sv]
// generic single-write, two-read synchronous ram with registered read data
module wpcn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[rtl/core/weighted_pair_count_normalizer.sv]
// top level of the weighted pair-count normalizer
// Usage:
// Items arrive on the in_ channel (valid/ready) with operation, index_a,
// index_b and weight_value. Clear starts a sight line, load writes a star
// weight and updates the weight and square sums, pair and random items add
// stored weights to the bin accumulators, close emits one result transfer
// on the out_ channel with bin_number, mm_value, mr_value, model_value and
// norm_error.
// Timing: every item passes S_IDLE and S_EXEC in the core (weight read from
// the two-port weight ram, then accumulate); no new item is taken before the
// core is back in S_IDLE. A close item additionally runs the norm products in
// S_MUL1 and S_MUL2, then two restoring dividers in parallel, one quotient
// bit per cycle over 128 numerator bits, and S_FIN offers the result.
// The result sits in an output register; the next item is taken while it
// waits, and only a further close stalls until it has been taken.
// Reset clears the sums, accumulators and bin counter and sets random_count
// to 1; the weight ram keeps undefined contents until loaded.
// The user writes random_count through cfg_we/cfg_data only while the block
// is idle; the block itself does not enforce this.
module weighted_pair_count_normalizer #(
    parameter int MAX_STARS   = 4096,
    parameter int WEIGHT_BITS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [23:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           operation,
    input  logic [11:0]          index_a,
    input  logic [11:0]          index_b,
    input  logic [23:0]          weight_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           bin_number,
    output logic [30:0]          mm_value,
    output logic [30:0]          mr_value,
    output logic signed [31:0]   model_value,
    output logic                 norm_error
);
    import wpcn_pkg::*;

    localparam int AW = (MAX_STARS > 1) ? $clog2(MAX_STARS) : 1;
    localparam int WB = (WEIGHT_BITS < 24) ? WEIGHT_BITS : 24;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_MUL1 = 6'b000100,
        S_MUL2 = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]  rcount_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [SQUARE_W-1:0] square_reg;
    logic [PAIR_W-1:0]   pair_reg;
    logic [RAND_W-1:0]   rand_reg;
    logic [7:0]          bin_reg;

    // latched item
    logic [2:0]  op_reg;
    logic        a_ok_reg, b_ok_reg;
    logic [23:0] wv_reg;

    logic [23:0] rd_a, rd_b;
    logic        in_fire;
    logic        a_in, b_in;

    assign in_fire = in_valid && in_ready;
    assign a_in = ({20'd0, index_a} < 32'(MAX_STARS));
    assign b_in = ({20'd0, index_b} < 32'(MAX_STARS));

    // weight ram
    wpcn_ram #(.WIDTH(24), .DEPTH(MAX_STARS)) u_ram (
        .clk     (clk),
        .we      (in_fire && (operation == OP_LOAD) && a_in),
        .waddr   (AW'(index_a)),
        .wdata   (weight_value & 24'((25'd1 << WB) - 25'd1)),
        .raddr_a (AW'(index_a)),
        .raddr_b (AW'(index_b)),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // operand weights, out of range reads as zero
    logic [23:0] wa, wb;
    assign wa = a_ok_reg ? rd_a : 24'd0;
    assign wb = b_ok_reg ? rd_b : 24'd0;

    // pair product and load square
    logic [47:0] pair_prod;
    logic [47:0] wsq;
    assign pair_prod = {24'd0, wa} * {24'd0, wb};
    assign wsq = {24'd0, wv_reg} * {24'd0, wv_reg};

    // close-bin arithmetic
    logic [71:0]  sq_reg;
    logic [59:0]  mrn_reg;
    logic [127:0] n1_rem_reg, n2_rem_reg;
    logic [127:0] n1_num_reg, n2_num_reg;
    logic [127:0] d1_reg, d2_reg;
    logic [30:0]  q1_reg, q2_reg;
    logic         sat1_reg, sat2_reg;
    logic [6:0]   cnt_reg;
    logic         err_reg;

    logic [71:0]  diff;
    logic         sq_ge;
    assign sq_ge = sq_reg >= {12'd0, square_reg};
    assign diff  = sq_reg - {12'd0, square_reg};

    // divider step
    logic [127:0] r1s, r2s;
    logic         g1, g2;
    assign r1s = {n1_rem_reg[126:0], n1_num_reg[127]};
    assign r2s = {n2_rem_reg[126:0], n2_num_reg[127]};
    assign g1  = r1s >= d1_reg;
    assign g2  = r2s >= d2_reg;

    // output holding
    logic        ov_reg;
    logic [7:0]  ob_reg;
    logic [30:0] om_reg, or_reg;
    logic [31:0] omod_reg;
    logic        oe_reg;

    assign in_ready = (state_reg == S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) state_next = S_EXEC;
            S_EXEC: state_next = (op_reg == OP_CLOSE) ? S_MUL1 : S_IDLE;
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_DIV;
            S_DIV:  if (cnt_reg == 7'd127) state_next = S_FIN;
            S_FIN:  if (!ov_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // model difference
    logic signed [33:0] mdiff;
    assign mdiff = $signed({3'd0, (sat1_reg ? Q31_MAX : q1_reg)})
                 - $signed({2'd0, (sat2_reg ? Q31_MAX : q2_reg), 1'b0});

    // sequential datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rcount_reg <= 24'd1;
            total_reg  <= '0;
            square_reg <= '0;
            pair_reg   <= '0;
            rand_reg   <= '0;
            bin_reg    <= '0;
            ov_reg     <= 1'b0;
            op_reg     <= OP_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                rcount_reg <= cfg_data;
            end
            if (out_valid && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (in_fire)
            begin
                op_reg   <= operation;
                a_ok_reg <= a_in;
                b_ok_reg <= b_in;
                wv_reg   <= weight_value & 24'((25'd1 << WB) - 25'd1);
            end
            if (state_reg == S_EXEC)
            begin
                case (op_reg)
                    OP_CLEAR:
                    begin
                        total_reg  <= '0;
                        square_reg <= '0;
                        pair_reg   <= '0;
                        rand_reg   <= '0;
                        bin_reg    <= '0;
                    end
                    OP_LOAD:
                    begin
                        if (a_ok_reg)
                        begin
                            total_reg <= ({1'b0, total_reg} + 37'(wv_reg) > 37'({TOTAL_W{1'b1}}))
                                       ? {TOTAL_W{1'b1}} : total_reg + 36'(wv_reg);
                            square_reg <= ({1'b0, square_reg} + 61'(wsq) > 61'({SQUARE_W{1'b1}}))
                                        ? {SQUARE_W{1'b1}} : square_reg + 60'(wsq);
                        end
                    end
                    OP_PAIR:
                    begin
                        pair_reg <= ({1'b0, pair_reg} + 65'(pair_prod) > 65'({PAIR_W{1'b1}}))
                                  ? {PAIR_W{1'b1}} : pair_reg + 64'(pair_prod);
                    end
                    OP_RANDOM:
                    begin
                        rand_reg <= ({1'b0, rand_reg} + 37'(wa) > 37'({RAND_W{1'b1}}))
                                  ? {RAND_W{1'b1}} : rand_reg + 36'(wa);
                    end
                    default: ;
                endcase
            end
            if (state_reg == S_MUL1)
            begin
                sq_reg  <= {36'd0, total_reg} * {36'd0, total_reg};
                mrn_reg <= total_reg * 60'(rcount_reg);
            end
            if (state_reg == S_MUL2)
            begin
                d1_reg     <= sq_ge ? {57'd0, diff[71:1]} : '0;
                d2_reg     <= {68'd0, mrn_reg};
                err_reg    <= !sq_ge || (diff[71:1] == '0) || (mrn_reg == '0);
                n1_num_reg <= {35'd0, pair_reg, 29'd0};
                n2_num_reg <= {63'd0, rand_reg, 29'd0};
                n1_rem_reg <= '0;
                n2_rem_reg <= '0;
                q1_reg     <= '0;
                q2_reg     <= '0;
                sat1_reg   <= 1'b0;
                sat2_reg   <= 1'b0;
                cnt_reg    <= '0;
            end
            if (state_reg == S_DIV)
            begin
                cnt_reg    <= cnt_reg + 7'd1;
                n1_num_reg <= {n1_num_reg[126:0], 1'b0};
                n2_num_reg <= {n2_num_reg[126:0], 1'b0};
                n1_rem_reg <= g1 ? r1s - d1_reg : r1s;
                n2_rem_reg <= g2 ? r2s - d2_reg : r2s;
                if (g1)
                begin
                    if (cnt_reg <= 7'd96) sat1_reg <= 1'b1;
                    else q1_reg[5'(7'd127 - cnt_reg)] <= 1'b1;
                end
                if (g2)
                begin
                    if (cnt_reg <= 7'd96) sat2_reg <= 1'b1;
                    else q2_reg[5'(7'd127 - cnt_reg)] <= 1'b1;
                end
            end
            if ((state_reg == S_FIN) && !ov_reg)
            begin
                ov_reg   <= 1'b1;
                ob_reg   <= bin_reg;
                oe_reg   <= err_reg;
                om_reg   <= err_reg ? '0 : (sat1_reg ? Q31_MAX : q1_reg);
                or_reg   <= err_reg ? '0 : (sat2_reg ? Q31_MAX : q2_reg);
                omod_reg <= err_reg ? '0 :
                            (mdiff < -34'sd2147483648) ? 32'h8000_0000 :
                            (mdiff > 34'sd2147483647) ? 32'h7FFF_FFFF : mdiff[31:0];
                pair_reg <= '0;
                rand_reg <= '0;
                bin_reg  <= bin_reg + 8'd1;
            end
        end
    end

    assign out_valid   = ov_reg;
    assign bin_number  = ob_reg;
    assign mm_value    = om_reg;
    assign mr_value    = or_reg;
    assign model_value = omod_reg;
    assign norm_error  = oe_reg;

endmodule

[test/tb_weighted_pair_count_normalizer.sv]
// testbench for the weighted pair-count normalizer: directed and random items checked against a predictor
`timescale 1ns / 100ps

module tb_weighted_pair_count_normalizer;
    import wpcn_pkg::*;

    localparam int          STAR_COUNT   = 4096;
    localparam int          MAX_GAP      = 11;
    localparam int          DRAIN_CYCLES = 200;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          LONG_HOLD    = 600;
    localparam logic [2:0]  OP_SPARE_LO  = 3'd5;
    localparam logic [2:0]  OP_SPARE_MID = 3'd6;
    localparam logic [2:0]  OP_SPARE_HI  = 3'd7;
    localparam logic [23:0] COUNT_MAX    = 24'hFFFFFF;

    typedef struct packed {
        logic [2:0]  op;
        logic [11:0] idx_a;
        logic [11:0] idx_b;
        logic [23:0] weight;
    } star_item_t;

    typedef struct packed {
        logic [7:0]         bin;
        logic [30:0]        mm;
        logic [30:0]        mr;
        logic signed [31:0] model;
        logic               err;
    } bin_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  operation;
    logic [11:0] index_a;
    logic [11:0] index_b;
    logic [23:0] weight_value;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  bin_number;
    logic [30:0] mm_value;
    logic [30:0] mr_value;
    logic signed [31:0] model_value;
    logic        norm_error;

    // predictor state
    logic [23:0] star_weight [STAR_COUNT];
    logic [35:0] sum_weight;
    logic [59:0] sum_square;
    logic [63:0] pair_sum;
    logic [35:0] random_sum;
    logic [7:0]  bin_index;
    logic [23:0] catalog_size;

    // stimulus bookkeeping
    star_item_t  pending_items[$];
    bin_result_t expected_bins[$];
    bit          star_loaded [STAR_COUNT];
    int          loaded_stars[$];
    int          items_queued;

    int          gap_left;
    int          stall_left;
    logic        rx_ready;
    int          hold_left;
    bit          hold_done;
    int          results_seen;
    int          error_bins;
    int          mismatches;
    int          cycle_count;

    weighted_pair_count_normalizer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .index_a      (index_a),
        .index_b      (index_b),
        .weight_value (weight_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bin_number   (bin_number),
        .mm_value     (mm_value),
        .mr_value     (mr_value),
        .model_value  (model_value),
        .norm_error   (norm_error)
    );

    assign out_ready = rx_ready && (hold_left == 0);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // quotient scaled by 2^29, truncated and saturated to 31 bits
    function automatic logic [30:0] scaled_quotient(logic [127:0] num, logic [127:0] den);
        logic [127:0] q;
        q = (num << FRAC_SH) / den;
        if (q > {97'd0, Q31_MAX})
            return Q31_MAX;
        return q[30:0];
    endfunction

    // apply one accepted item to the predictor state
    function automatic void apply_item(star_item_t it);
        logic [36:0]  wsum;
        logic [60:0]  qsum;
        logic [64:0]  psum;
        logic [127:0] sq;
        logic [127:0] mm_norm;
        logic [127:0] mr_norm;
        logic signed [63:0] diff;
        bin_result_t  r;
        case (it.op)
            OP_CLEAR:
            begin
                sum_weight = '0;
                sum_square = '0;
                pair_sum   = '0;
                random_sum = '0;
                bin_index  = '0;
            end
            OP_LOAD:
            begin
                star_weight[it.idx_a] = it.weight;
                wsum = {1'b0, sum_weight} + it.weight;
                sum_weight = wsum[36] ? '1 : wsum[35:0];
                qsum = {1'b0, sum_square} + 61'(48'(it.weight) * 48'(it.weight));
                sum_square = qsum[60] ? '1 : qsum[59:0];
            end
            OP_PAIR:
            begin
                psum = {1'b0, pair_sum}
                     + 65'(48'(star_weight[it.idx_a]) * 48'(star_weight[it.idx_b]));
                pair_sum = psum[64] ? '1 : psum[63:0];
            end
            OP_RANDOM:
            begin
                wsum = {1'b0, random_sum} + star_weight[it.idx_a];
                random_sum = wsum[36] ? '1 : wsum[35:0];
            end
            OP_CLOSE:
            begin
                sq      = 128'(sum_weight) * 128'(sum_weight);
                mm_norm = (sq >= 128'(sum_square)) ? (sq - 128'(sum_square)) >> 1 : '0;
                mr_norm = 128'(sum_weight) * 128'(catalog_size);
                r.bin   = bin_index;
                r.err   = (mm_norm == 0) || (mr_norm == 0);
                r.mm    = '0;
                r.mr    = '0;
                r.model = '0;
                if (!r.err)
                begin
                    r.mm = scaled_quotient(128'(pair_sum), mm_norm);
                    r.mr = scaled_quotient(128'(random_sum), mr_norm);
                    diff = 64'(r.mm) - 2 * 64'(r.mr);
                    if (diff < -64'sd2147483648)
                        diff = -64'sd2147483648;
                    r.model = diff[31:0];
                end
                expected_bins.push_back(r);
                pair_sum   = '0;
                random_sum = '0;
                bin_index  = bin_index + 8'd1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // queue one item; loads also mark the star as usable by later pairs
    task automatic queue_item(logic [2:0] op, int a, int b, int unsigned w);
        star_item_t it;
        it.op     = op;
        it.idx_a  = a[11:0];
        it.idx_b  = b[11:0];
        it.weight = w[23:0];
        if (op == OP_LOAD && !star_loaded[a])
        begin
            star_loaded[a] = 1'b1;
            loaded_stars.push_back(a);
        end
        if (op <= OP_CLOSE)
            items_queued++;
        pending_items.push_back(it);
    endtask

    function automatic int any_loaded_star();
        return loaded_stars[$urandom_range(0, loaded_stars.size() - 1)];
    endfunction

    function automatic int unsigned draw_weight();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 24'hFFFFFF);
            1:       return $urandom_range(0, 255);
            default: return $urandom_range(24'h001000, 24'h040000);
        endcase
    endfunction

    function automatic int draw_gap();
        if (cycle_count[9] || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // one sight line: optional clear, loads, then several bins
    task automatic queue_sight_line();
        int n_bins;
        int n_items;
        if ($urandom_range(0, 7) != 0)
            queue_item(OP_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom);
        repeat ($urandom_range(2, 16))
            queue_item(OP_LOAD, $urandom_range(0, 4095), $urandom_range(0, 4095), draw_weight());
        n_bins = $urandom_range(1, 6);
        repeat (n_bins)
        begin
            n_items = $urandom_range(0, 10);
            repeat (n_items)
            begin
                case ($urandom_range(0, 19))
                    0:       queue_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                                        $urandom_range(0, 4095), $urandom_range(0, 4095),
                                        $urandom);
                    1:       queue_item(OP_LOAD, $urandom_range(0, 4095),
                                        $urandom_range(0, 4095), draw_weight());
                    2:       queue_item(OP_CLOSE, $urandom_range(0, 4095),
                                        $urandom_range(0, 4095), $urandom);
                    3, 4, 5: queue_item(OP_RANDOM, any_loaded_star(),
                                        $urandom_range(0, 4095), $urandom);
                    default: queue_item(OP_PAIR, any_loaded_star(), any_loaded_star(),
                                        $urandom);
                endcase
            end
            queue_item(OP_CLOSE, $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom);
        end
    endtask

    // wait for the block to drain, then the divider latency
    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_bins.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_catalog_size(logic [23:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        catalog_size = value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // driver: feeds the input channel from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        star_item_t nxt;
        int         g;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            operation    <= OP_CLEAR;
            index_a      <= '0;
            index_b      <= '0;
            weight_value <= '0;
            gap_left     <= 0;
        end
        else
        begin
            g = gap_left;
            if (in_valid && in_ready)
            begin
                apply_item('{operation, index_a, index_b, weight_value});
                g = draw_gap();
            end
            if (in_valid && !in_ready)
            begin
                // hold the offered item
            end
            else if (g != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= g - 1;
            end
            else if (pending_items.size() != 0)
            begin
                nxt = pending_items.pop_front();
                operation    <= nxt.op;
                index_a      <= nxt.idx_a;
                index_b      <= nxt.idx_b;
                weight_value <= nxt.weight;
                in_valid     <= 1'b1;
                gap_left     <= 0;
            end
            else
            begin
                in_valid <= 1'b0;
                gap_left <= 0;
            end
        end
    end

    task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] act_v,
                                ref int n);
        if (exp_v != act_v)
        begin
            if (mismatches + n < 10)
                $display("mismatch %s: expected %0h, got %0h", name, exp_v, act_v);
            n++;
        end
    endtask

    // monitor: checks each result transfer and draws receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        bin_result_t e;
        int          n;
        if (!rst_n)
        begin
            rx_ready     <= 1'b0;
            stall_left   <= 0;
            results_seen <= 0;
            error_bins   <= 0;
            mismatches   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n = 0;
                if (expected_bins.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result transfer, bin %0d", bin_number);
                    n = 1;
                end
                else
                begin
                    e = expected_bins.pop_front();
                    report_field("bin_number", 64'(e.bin), 64'(bin_number), n);
                    report_field("mm_value", 64'(e.mm), 64'(mm_value), n);
                    report_field("mr_value", 64'(e.mr), 64'(mr_value), n);
                    report_field("model_value", 64'(e.model), 64'(model_value), n);
                    report_field("norm_error", 64'(e.err), 64'(norm_error), n);
                    if (e.err)
                        error_bins <= error_bins + 1;
                end
                mismatches   <= mismatches + n;
                results_seen <= results_seen + 1;
                stall_left   <= draw_gap();
                rx_ready     <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                rx_ready   <= 1'b0;
            end
            else
                rx_ready <= 1'b1;
        end
    end

    // one long receiver hold-off so the block backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_seen == 30)
        begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus phases
    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        items_queued = 0;
        sum_weight   = '0;
        sum_square   = '0;
        pair_sum     = '0;
        random_sum   = '0;
        bin_index    = '0;
        catalog_size = 24'd1;
        foreach (star_loaded[i])
        begin
            star_loaded[i] = 1'b0;
            star_weight[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty bin, extremes, reload, spare codes, saturation, lone star
        queue_item(OP_CLEAR, 0, 0, 0);
        queue_item(OP_CLOSE, 0, 0, 0);
        queue_item(OP_LOAD, 0, 4095, 24'hFFFFFF);
        queue_item(OP_LOAD, 4095, 0, 24'h000000);
        queue_item(OP_LOAD, 12'hAAA, 12'h555, 24'h555555);
        queue_item(OP_LOAD, 12'h555, 12'hAAA, 24'hAAAAAA);
        queue_item(OP_LOAD, 12'h555, 0, 24'h000001);
        queue_item(OP_PAIR, 0, 4095, 0);
        queue_item(OP_PAIR, 0, 0, 0);
        queue_item(OP_PAIR, 12'h555, 12'hAAA, 0);
        queue_item(OP_RANDOM, 0, 0, 0);
        queue_item(OP_RANDOM, 4095, 0, 0);
        queue_item(OP_SPARE_LO, 4095, 4095, 24'hFFFFFF);
        queue_item(OP_SPARE_MID, 0, 0, 0);
        queue_item(OP_SPARE_HI, 12'hAAA, 12'h555, 24'hAAAAAA);
        queue_item(OP_CLOSE, 4095, 4095, 24'hFFFFFF);
        queue_item(OP_CLEAR, 0, 0, 0);
        queue_item(OP_LOAD, 1, 0, 24'h000001);
        queue_item(OP_LOAD, 2, 0, 24'h000001);
        queue_item(OP_PAIR, 0, 0, 0);
        queue_item(OP_RANDOM, 0, 0, 0);
        queue_item(OP_CLOSE, 0, 0, 0);
        queue_item(OP_CLEAR, 0, 0, 0);
        queue_item(OP_LOAD, 3, 0, 24'h123456);
        queue_item(OP_CLOSE, 0, 0, 0);
        wait_idle();

        // widest catalog, then a long sight line that wraps the bin counter
        write_catalog_size(COUNT_MAX);
        queue_item(OP_CLEAR, 0, 0, 0);
        repeat (3)
            queue_item(OP_LOAD, $urandom_range(0, 4095), 0, draw_weight());
        repeat (260)
        begin
            queue_item(OP_PAIR, any_loaded_star(), any_loaded_star(), 0);
            queue_item(OP_CLOSE, 0, 0, 0);
        end
        wait_idle();

        // random sight lines over several catalog sizes
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       write_catalog_size(24'd1);
                1:       write_catalog_size(24'($urandom_range(2, 255)));
                2:       write_catalog_size(24'($urandom_range(1, COUNT_MAX)));
                default: write_catalog_size(COUNT_MAX);
            endcase
            while (items_queued < 550 + (phase + 1) * 250)
                queue_sight_line();
            wait_idle();
        end

        $display("%0d items sent, %0d bins checked (%0d with zero norm), bin counter wrapped",
                 items_queued, results_seen, error_bins);
        $display("long receiver hold-off applied, %0d mismatches", mismatches);
        if (mismatches == 0 && expected_bins.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
